// ===== design/m64a_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helpers for the MurmurHash64A unit.
// No dependencies; used by the multiplier, the top level and the testbench.
package m64a_pkg;

	localparam logic [63:0] MUL_M      = 64'hc6a4a7935bd1e995;
	localparam logic [31:0] MUL_M_LO   = MUL_M[31:0];
	localparam logic [31:0] MUL_M_HI   = MUL_M[63:32];
	localparam int unsigned SHIFT_R    = 47;
	localparam logic [63:0] SEED_RESET = 64'h000000005bd1e995;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_OUT
	} state_t;

	// what to do with the product when the multiplier finishes
	typedef enum logic [2:0] {
		PH_LEN,
		PH_W1,
		PH_W2,
		PH_H,
		PH_TAIL,
		PH_FIN
	} phase_t;

	typedef struct packed {
		logic [63:0] x;
		phase_t      ph;
	} disp_t;

	function automatic logic [63:0] xs47(input logic [63:0] v);
		return v ^ (v >> SHIFT_R);
	endfunction

	// first multiply for a word, given the running hash and the word
	function automatic disp_t dispatch(input logic [63:0] h, input logic [63:0] word,
		input logic last, input logic [31:0] len);
		disp_t       d;
		logic [63:0] mask;
		mask = '0;
		for (int i = 0; i < 8; i++) begin
			if (3'(i) < len[2:0]) mask[i*8 +: 8] = 8'hff;
		end
		if (!last) begin
			d.x  = word;
			d.ph = PH_W1;
		end else if (len[2:0] != 3'd0) begin
			d.x  = h ^ (word & mask);
			d.ph = PH_TAIL;
		end else if (len != 32'd0) begin
			d.x  = word;
			d.ph = PH_W1;
		end else begin
			d.x  = xs47(h);
			d.ph = PH_FIN;
		end
		return d;
	endfunction

endpackage

// ===== design/m64a_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the MurmurHash64A unit.
// No dependencies.
interface m64a_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [31:0] message_length;
	logic        last;
	modport source (output valid, data_word, message_length, last, input ready);
	modport sink   (input valid, data_word, message_length, last, output ready);
endinterface

interface m64a_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;
	modport source (output valid, hash_value, input ready);
	modport sink   (input valid, hash_value, output ready);
endinterface

interface m64a_cfg_if;
	logic        valid;
	logic        ready;
	logic [63:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ===== design/murmur64a_hash_unit.sv =====
`timescale 1ns / 1ps
// Top level of the MurmurHash64A unit: sequencer around m64a_mul.
// Depends on m64a_pkg, m64a_ifs and m64a_mul.
//
// Usage:
//   req carries one 64-bit word per handshake: data_word (little endian),
//   message_length (sampled only on the first word of a message) and last.
//   rsp returns one hash_value per message, after the word marked last.
//   cfg writes the 64-bit seed (reset 0x5bd1e995); it is always ready and
//   should be written only between messages.
// Timing:
//   every 64-bit multiply by M runs on the single 32x32 multiplier of m64a_mul.
//   First word of a message: an extra multiply for length * M.
//   Full word: 3 multiplies, then req.ready goes high again; a new word is
//   taken only once the previous one is done.
//   Last word: tail fold (one multiply) or full mix (3 multiplies), then the
//   finalizer multiply and the ST_OUT state, which loads the output register.
//   An empty message needs only the length and finalizer multiplies.
//   req.ready is low while a word is being processed.
// Reset clears the message state and the output valid flag and loads the seed.
// rsp has its own output register: a stalled receiver does not block the
// next message until a second hash is finished and waits for the slot.
module murmur64a_hash_unit (
	input  logic                clk,
	input  logic                arst_n,
	m64a_in_if.sink             req,
	m64a_out_if.source          rsp,
	m64a_cfg_if.sink            cfg
);

	m64a_pkg::state_t state_q, state_nxt;
	m64a_pkg::phase_t phase_q, phase_nxt;
	m64a_pkg::disp_t  d;

	logic [63:0] seed_q;
	logic [63:0] h_q, h_nxt;
	logic [63:0] word_q;
	logic        last_q;
	logic [31:0] len_q, len_nxt;
	logic        in_msg_q, in_msg_nxt;
	logic [63:0] hash_q;
	logic        out_valid_q;
	logic        out_load;
	logic        accept;

	logic        mul_start;
	logic [63:0] mul_x;
	logic [63:0] r;
	logic        mul_done;

	m64a_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.prod   (r),
		.done   (mul_done)
	);

	assign req.ready = (state_q == m64a_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	always_comb begin
		state_nxt  = state_q;
		phase_nxt  = phase_q;
		h_nxt      = h_q;
		len_nxt    = len_q;
		in_msg_nxt = in_msg_q;
		mul_start  = 1'b0;
		mul_x      = '0;
		out_load   = 1'b0;
		d          = m64a_pkg::dispatch(h_q, req.data_word, req.last, len_q);
		unique case (state_q)
			m64a_pkg::ST_IDLE: begin
				if (accept) begin
					mul_start  = 1'b1;
					in_msg_nxt = 1'b1;
					state_nxt  = m64a_pkg::ST_BUSY;
					if (!in_msg_q) begin
						len_nxt   = req.message_length;
						mul_x     = {32'd0, req.message_length};
						phase_nxt = m64a_pkg::PH_LEN;
					end else begin
						mul_x     = d.x;
						phase_nxt = d.ph;
					end
				end
			end
			m64a_pkg::ST_BUSY: begin
				if (mul_done) begin
					unique case (phase_q)
						m64a_pkg::PH_LEN: begin
							h_nxt     = seed_q ^ r;
							d         = m64a_pkg::dispatch(seed_q ^ r, word_q, last_q, len_q);
							mul_start = 1'b1;
							mul_x     = d.x;
							phase_nxt = d.ph;
						end
						m64a_pkg::PH_W1: begin
							mul_start = 1'b1;
							mul_x     = m64a_pkg::xs47(r);
							phase_nxt = m64a_pkg::PH_W2;
						end
						m64a_pkg::PH_W2: begin
							mul_start = 1'b1;
							mul_x     = h_q ^ r;
							phase_nxt = m64a_pkg::PH_H;
						end
						m64a_pkg::PH_H: begin
							h_nxt = r;
							if (last_q) begin
								mul_start = 1'b1;
								mul_x     = m64a_pkg::xs47(r);
								phase_nxt = m64a_pkg::PH_FIN;
							end else begin
								state_nxt = m64a_pkg::ST_IDLE;
							end
						end
						m64a_pkg::PH_TAIL: begin
							mul_start = 1'b1;
							mul_x     = m64a_pkg::xs47(r);
							phase_nxt = m64a_pkg::PH_FIN;
						end
						m64a_pkg::PH_FIN: begin
							h_nxt     = m64a_pkg::xs47(r);
							state_nxt = m64a_pkg::ST_OUT;
						end
						default: begin
							state_nxt = m64a_pkg::ST_IDLE;
						end
					endcase
				end
			end
			m64a_pkg::ST_OUT: begin
				// wait for a free output slot
				if (!out_valid_q || rsp.ready) begin
					out_load   = 1'b1;
					h_nxt      = '0;
					len_nxt    = '0;
					in_msg_nxt = 1'b0;
					state_nxt  = m64a_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = m64a_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= m64a_pkg::ST_IDLE;
			phase_q     <= m64a_pkg::PH_LEN;
			in_msg_q    <= 1'b0;
			h_q         <= '0;
			len_q       <= '0;
			seed_q      <= m64a_pkg::SEED_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			phase_q  <= phase_nxt;
			in_msg_q <= in_msg_nxt;
			h_q      <= h_nxt;
			len_q    <= len_nxt;
			if (cfg.valid) seed_q <= cfg.data;
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= req.data_word;
			last_q <= req.last;
		end
		if (out_load) hash_q <= h_q;
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.hash_value = hash_q;

endmodule

// ===== design/m64a_mul.sv =====
`timescale 1ns / 1ps
// Iterative 64-bit by constant multiplier (low 64 bits of x * M).
// One 32x32 multiplier used three times; depends on m64a_pkg.
module m64a_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] x,
	output logic [63:0] prod,
	output logic        done
);

	logic [63:0] xs_q;
	logic [63:0] acc_q;
	logic [1:0]  cnt_q;
	logic        done_q;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] p;

	always_comb begin
		if (start) begin
			op_a = x[31:0];
			op_b = m64a_pkg::MUL_M_LO;
		end else if (cnt_q == 2'd1) begin
			op_a = xs_q[63:32];
			op_b = m64a_pkg::MUL_M_LO;
		end else begin
			op_a = xs_q[31:0];
			op_b = m64a_pkg::MUL_M_HI;
		end
		p = op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 2'd2) && !start;
			if (start) cnt_q <= 2'd1;
			else if (cnt_q == 2'd1) cnt_q <= 2'd2;
			else cnt_q <= 2'd0;
		end
	end

	// cross terms only reach the upper half
	always_ff @(posedge clk) begin
		if (start) begin
			xs_q  <= x;
			acc_q <= p;
		end else if (cnt_q != 2'd0) begin
			acc_q <= acc_q + {p[31:0], 32'd0};
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

// ===== dv/murmur64a_hash_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for murmur64a_hash_unit: drives words, checks each hash.
// Depends on m64a_pkg, m64a_ifs and the design top level.
module murmur64a_hash_unit_tb;

	localparam int unsigned LIMIT_CYCLES = 1000000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned HOLD_CYCLES  = 600;
	localparam int unsigned RANDOM_ITEMS = 1550;
	localparam int unsigned PHASES       = 4;

	typedef enum int {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES
	} fill_t;

	// tracks the hash of the open message and the hashes still to come out
	class hash_scoreboard;
		logic [63:0] seed;
		logic [63:0] running_hash;
		logic        open;
		logic [31:0] held_length;
		logic [63:0] hash_q[$];
		int          errors;

		function new();
			seed         = m64a_pkg::SEED_RESET;
			running_hash = '0;
			open         = 1'b0;
			held_length  = '0;
			errors       = 0;
		endfunction

		function logic [63:0] mix(input logic [63:0] h, input logic [63:0] w);
			w = w * m64a_pkg::MUL_M;
			w = w ^ (w >> m64a_pkg::SHIFT_R);
			w = w * m64a_pkg::MUL_M;
			h = h ^ w;
			return h * m64a_pkg::MUL_M;
		endfunction

		function logic [63:0] finalize(input logic [63:0] h);
			h = h ^ (h >> m64a_pkg::SHIFT_R);
			h = h * m64a_pkg::MUL_M;
			return h ^ (h >> m64a_pkg::SHIFT_R);
		endfunction

		function void note_word(input logic [63:0] w, input logic [31:0] len,
			input logic lst);
			logic [63:0] h;
			logic [63:0] mask;
			int unsigned tail;
			if (!open) begin
				held_length  = len;
				running_hash = seed ^ (64'(held_length) * m64a_pkg::MUL_M);
				open         = 1'b1;
			end
			h = running_hash;
			if (!lst) begin
				running_hash = mix(h, w);
				return;
			end
			tail = {29'd0, held_length[2:0]};
			if (tail != 0) begin
				// bytes above the tail count do not take part
				mask = (64'd1 << (8 * tail)) - 64'd1;
				h    = (h ^ (w & mask)) * m64a_pkg::MUL_M;
			end else if (held_length != 0) begin
				h = mix(h, w);
			end
			hash_q.push_back(finalize(h));
			running_hash = '0;
			open         = 1'b0;
			held_length  = '0;
		endfunction

		function void check_hash(input logic [63:0] got);
			logic [63:0] exp;
			if (hash_q.size() == 0) begin
				$error("hash_value unexpected: expected none, actual %h", got);
				errors++;
				return;
			end
			exp = hash_q.pop_front();
			if (got !== exp) begin
				$error("hash_value mismatch: expected %h, actual %h", exp, got);
				errors++;
			end
		endfunction

		function int pending();
			return hash_q.size();
		endfunction

		function void flush_check();
			if (hash_q.size() != 0) begin
				$error("hash_value missing: expected %0d more, actual 0", hash_q.size());
				errors += hash_q.size();
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	m64a_in_if  req ();
	m64a_out_if rsp ();
	m64a_cfg_if cfg ();

	murmur64a_hash_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	hash_scoreboard sb;
	int unsigned    items_sent;
	int unsigned    phase_target;
	int             burst_left;
	bit             hold_req;
	int             rx_mode;
	int             rx_span;
	logic [63:0]    phase_seed;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_hash(rsp.hash_value);
	end

	initial begin : watchdog
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("murmur64a_hash_unit test failed");
		$finish;
	end

	// receiver: changing stall patterns, one long hold-off on request
	initial begin : receiver
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) begin
					@(posedge clk);
					rsp.ready <= 1'b0;
				end
			end
			rx_mode = $urandom_range(0, 3);
			rx_span = $urandom_range(30, 300);
			repeat (rx_span) begin
				@(posedge clk);
				case (rx_mode)
					0: rsp.ready <= 1'b1;
					1: rsp.ready <= 1'($urandom_range(0, 1));
					2: rsp.ready <= ($urandom_range(0, 7) == 0);
					default: rsp.ready <= ~rsp.ready;
				endcase
			end
		end
	end

	function automatic logic [63:0] pick_word(input fill_t fill);
		case (fill)
			FILL_ZERO: return '0;
			FILL_ONES: return '1;
			default:   return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_word(input logic [63:0] w, input logic [31:0] len, input logic lst);
		int gap;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.valid          <= 1'b1;
		req.data_word      <= w;
		req.message_length <= len;
		req.last           <= lst;
		do @(posedge clk); while (!req.ready);
		sb.note_word(w, len, lst);
		items_sent++;
	endtask

	// length rides on the first word only; later words carry junk there
	task automatic send_message(input logic [31:0] len, input int nwords, input fill_t fill);
		for (int i = 0; i < nwords; i++)
			send_word(pick_word(fill), (i == 0) ? len : $urandom, i == nwords - 1);
	endtask

	task automatic stop_input();
		req.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [63:0] value);
		cfg.valid <= 1'b1;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		sb.seed = value;
	endtask

	task automatic random_message();
		int          kind;
		int          sel;
		logic [31:0] len;
		int          nwords;
		kind = $urandom_range(0, 19);
		if (kind < 17) begin
			sel = $urandom_range(0, 9);
			case (sel)
				0: len = 0;
				8: len = $urandom_range(65, 160);
				9: len = 8 * $urandom_range(1, 8);
				default: len = $urandom_range(1, 64);
			endcase
			nwords = (len == 0) ? 1 : (len + 7) / 8;
		end else if (kind < 19) begin
			// huge length, only a few words supplied
			len    = $urandom;
			nwords = $urandom_range(1, 5);
		end else begin
			len    = $urandom_range(0, 80);
			nwords = $urandom_range(1, 12);
		end
		send_message(len, nwords, FILL_RANDOM);
	endtask

	initial begin : main
		sb = new();
		arst_n             <= 1'b0;
		req.valid          <= 1'b0;
		req.data_word      <= '0;
		req.message_length <= '0;
		req.last           <= 1'b0;
		cfg.valid          <= 1'b0;
		cfg.data           <= '0;
		items_sent = 0;
		burst_left = 0;
		hold_req   = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (DRAIN_CYCLES) @(posedge clk);

		// directed part, reset seed
		send_message(0, 1, FILL_ZERO);
		for (int n = 1; n <= 8; n++)
			send_message(n, 1, (n == 3) ? FILL_ZERO : FILL_ONES);
		send_message(16, 2, FILL_ONES);
		send_message(16, 2, FILL_ZERO);
		send_message(0, 3, FILL_ONES);
		send_message(32'hffffffff, 2, FILL_ONES);
		send_message(13, 2, FILL_RANDOM);

		// seed written mid-message leaves the open message on the old seed
		send_word('1, 20, 1'b0);
		stop_input();
		drain();
		write_seed({$urandom, $urandom});
		send_word({$urandom, $urandom}, $urandom, 1'b0);
		send_word({$urandom, $urandom}, $urandom, 1'b1);

		items_sent = 0;
		for (int p = 0; p < PHASES; p++) begin
			stop_input();
			drain();
			case (p)
				0: phase_seed = '0;
				1: phase_seed = '1;
				default: phase_seed = {$urandom, $urandom};
			endcase
			write_seed(phase_seed);
			if (p == 1)
				hold_req = 1'b1;
			phase_target = RANDOM_ITEMS * (p + 1) / PHASES;
			while (items_sent < phase_target)
				random_message();
		end
		stop_input();

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.flush_check();
		if (sb.errors == 0)
			$display("murmur64a_hash_unit test passed");
		else
			$display("murmur64a_hash_unit test failed");
		$finish;
	end

endmodule

// ===== files.f =====
design/m64a_pkg.sv
design/m64a_ifs.sv
design/m64a_mul.sv
design/murmur64a_hash_unit.sv
dv/murmur64a_hash_unit_tb.sv
